/* hw/rtl/loqt_pkg.sv */
// shared types and constants for the label offset queue table
`timescale 1ns / 1ps

package loqt_pkg;

  // configuration register
  localparam int CFG_W = 10;
  localparam logic [CFG_W-1:0] MASK_RESET = 10'd1023;

  // sizing defaults
  localparam int SLOT_COUNT_DEF  = 1024;
  localparam int ENTRY_COUNT_DEF = 1024;

  // field widths
  localparam int LABEL_W = 32;
  localparam int VALUE_W = 32;
  localparam logic [LABEL_W-1:0] EMPTY_KEY = '1;

  // command codes
  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_LOOK = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_NOP,
    OP_ABSENT,
    OP_ENQ,
    OP_DEQ,
    OP_LOOK
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_ABSENT    = 3'd1,
    STS_FULL      = 3'd2,
    STS_EXHAUSTED = 3'd3,
    STS_EMPTY     = 3'd4
  } status_t;

  // one queued word
  typedef struct packed {
    op_t                op;
    logic [LABEL_W-1:0] label;
    logic [VALUE_W-1:0] offset;
  } item_t;

  // back end sequencer states
  typedef enum logic [3:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_PROBE_RD,
    BS_PROBE_CHK,
    BS_ENQ_WR,
    BS_ENQ_LINK,
    BS_DEQ_RD,
    BS_DEQ_WR,
    BS_LK_HEAD,
    BS_LK_TAIL,
    BS_LK_DONE,
    BS_OUT
  } bstate_t;

endpackage

/* hw/rtl/label_offset_queue_table.sv */
// top level of the label offset queue table
//
// channel   direction  signals
// in        input      in_valid, in_ready, cmd, label, offset
// out       output     out_valid, out_ready, status, first_offset, last_offset
// cfg       input      cfg_valid, cfg_ready, cfg_data (slot mask)
//
// after reset the slot table is cleared one slot a cycle, every slot, before the first
// word is taken. a word waits in the queue, then the back end classifies it and, when
// a probe is needed, loops over the slot memory read port one slot at a time, then
// does the list update, if any, and loads the result register.
// a two word queue lets the input side fill while the back end probes, and the
// result register lets the next word start while a result waits on out_ready.
`timescale 1ns / 1ps

module label_offset_queue_table import loqt_pkg::*; #(
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
  parameter int ENTRY_COUNT = ENTRY_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [LABEL_W-1:0] label,
  input  logic [VALUE_W-1:0] offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [VALUE_W-1:0] first_offset,
  output logic [VALUE_W-1:0] last_offset,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data
);

  logic       slot_mask;
  logic [CFG_W-1:0] slot_mask_q;
  logic       run;
  logic       q_push;
  logic       q_not_full;
  logic       q_pop;
  logic       q_not_empty;
  item_t      push_item;
  item_t      pop_item;

  // configuration register
  assign cfg_ready = 1'b1;
  assign slot_mask = cfg_valid & cfg_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_mask_q <= MASK_RESET;
    end else if (slot_mask) begin
      slot_mask_q <= cfg_data;
    end
  end

  // front end
  loqt_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .label    (label),
    .offset   (offset),
    .run      (run),
    .q_ready  (q_not_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  // queue between the two sides
  loqt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (pop_item)
  );

  // back end
  loqt_back #(
    .SLOT_COUNT  (SLOT_COUNT),
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .slot_mask    (slot_mask_q),
    .run          (run),
    .q_valid      (q_not_empty),
    .q_item       (pop_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .first_offset (first_offset),
    .last_offset  (last_offset)
  );

endmodule

/* hw/rtl/loqt_front.sv */
// front end: input handshake and command classification
`timescale 1ns / 1ps

module loqt_front import loqt_pkg::*; (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [LABEL_W-1:0] label,
  input  logic [VALUE_W-1:0] offset,
  input  logic               run,
  input  logic               q_ready,
  output logic               q_push,
  output item_t              q_item
);

  // held off while the slot table is being cleared or the queue is full
  assign in_ready = q_ready & run;
  assign q_push   = in_valid & in_ready;

  // classify the word
  always_comb begin
    q_item.label  = label;
    q_item.offset = offset;
    if (cmd != CMD_ENQ && cmd != CMD_DEQ && cmd != CMD_LOOK) begin
      q_item.op = OP_NOP;
    end else if (label == EMPTY_KEY) begin
      q_item.op = OP_ABSENT;
    end else if (cmd == CMD_ENQ) begin
      q_item.op = OP_ENQ;
    end else if (cmd == CMD_DEQ) begin
      q_item.op = OP_DEQ;
    end else begin
      q_item.op = OP_LOOK;
    end
  end

endmodule

/* hw/rtl/loqt_queue.sv */
// two word queue between front and back
`timescale 1ns / 1ps

module loqt_queue import loqt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  not_full,
  input  logic  pop,
  output logic  not_empty,
  output item_t pop_item
);

  item_t      words [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign not_full  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_item  = words[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      words[wptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* hw/rtl/loqt_back.sv */
// back end: slot probing, list update and result register
`timescale 1ns / 1ps

module loqt_back import loqt_pkg::*; #(
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
  parameter int ENTRY_COUNT = ENTRY_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [CFG_W-1:0]   slot_mask,
  output logic               run,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [VALUE_W-1:0] first_offset,
  output logic [VALUE_W-1:0] last_offset
);

  localparam int SW    = $clog2(SLOT_COUNT);
  localparam int EW    = $clog2(ENTRY_COUNT);
  localparam int LW    = $clog2(ENTRY_COUNT + 1);
  localparam int ROW_W = LABEL_W + 2 * LW;
  localparam logic [LW-1:0] LINK_NONE = LW'(ENTRY_COUNT);

  // memories
  logic [ROW_W-1:0]   slot_mem [SLOT_COUNT];
  logic [VALUE_W-1:0] val_mem  [ENTRY_COUNT];
  logic [LW-1:0]      link_mem [ENTRY_COUNT];

  logic               slot_we;
  logic [SW-1:0]      slot_wa;
  logic [ROW_W-1:0]   slot_wd;
  logic [ROW_W-1:0]   slot_rd;
  logic               val_we;
  logic [EW-1:0]      val_wa;
  logic [EW-1:0]      val_ra;
  logic [VALUE_W-1:0] val_rd;
  logic               link_we;
  logic [EW-1:0]      link_wa;
  logic [LW-1:0]      link_wd;
  logic [EW-1:0]      link_ra;
  logic [LW-1:0]      link_rd;

  // sequencer and datapath registers
  bstate_t            state;
  bstate_t            state_next;
  item_t              item;
  logic [SW-1:0]      idx;
  logic [SW:0]        step;
  logic [LW-1:0]      row_head;
  logic [LW-1:0]      row_tail;
  logic               is_new;
  logic [LW-1:0]      entries_used;
  status_t            res_status;
  logic [VALUE_W-1:0] res_first;
  logic [VALUE_W-1:0] res_last;

  // effective mask
  logic [SW+CFG_W-1:0] mask_wide;
  logic [SW-1:0]       mask;
  assign mask_wide = {{SW{1'b0}}, slot_mask};
  assign mask      = mask_wide[SW-1:0] & SW'(SLOT_COUNT - 1);

  // fields of the slot row just read
  logic [LABEL_W-1:0] rd_key;
  logic [LW-1:0]      rd_head;
  logic [LW-1:0]      rd_tail;
  assign rd_key  = slot_rd[ROW_W-1 -: LABEL_W];
  assign rd_head = slot_rd[2*LW-1 -: LW];
  assign rd_tail = slot_rd[LW-1:0];

  assign run = (state != BS_CLEAR);

  // slot memory
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd <= slot_mem[idx];
  end

  // entry value memory
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa] <= item.offset;
    end
    val_rd <= val_mem[val_ra];
  end

  // entry link memory
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd <= link_mem[link_ra];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory controls
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    slot_we    = 1'b0;
    slot_wa    = idx;
    slot_wd    = {item.label, row_head, row_tail};
    val_we     = 1'b0;
    val_wa     = entries_used[EW-1:0];
    val_ra     = row_head[EW-1:0];
    link_we    = 1'b0;
    link_wa    = entries_used[EW-1:0];
    link_wd    = LINK_NONE;
    link_ra    = row_head[EW-1:0];
    unique case (state)
      BS_CLEAR: begin
        slot_we = 1'b1;
        slot_wd = {EMPTY_KEY, {(2*LW){1'b0}}};
        if (idx == SW'(SLOT_COUNT - 1)) begin
          state_next = BS_IDLE;
        end
      end
      BS_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.op == OP_NOP || q_item.op == OP_ABSENT) begin
            state_next = BS_OUT;
          end else if (q_item.op == OP_ENQ && entries_used >= LINK_NONE) begin
            state_next = BS_OUT;
          end else begin
            state_next = BS_PROBE_RD;
          end
        end
      end
      BS_PROBE_RD: begin
        state_next = BS_PROBE_CHK;
      end
      BS_PROBE_CHK: begin
        if (rd_key == EMPTY_KEY) begin
          state_next = (item.op == OP_ENQ) ? BS_ENQ_WR : BS_OUT;
        end else if (rd_key == item.label) begin
          if (item.op == OP_ENQ) begin
            state_next = BS_ENQ_WR;
          end else if (rd_head >= LINK_NONE) begin
            state_next = BS_OUT;
          end else if (item.op == OP_DEQ) begin
            state_next = BS_DEQ_RD;
          end else begin
            state_next = BS_LK_HEAD;
          end
        end else if (step == {1'b0, mask}) begin
          state_next = BS_OUT;
        end else begin
          state_next = BS_PROBE_RD;
        end
      end
      BS_ENQ_WR: begin
        val_we  = 1'b1;
        link_we = 1'b1;
        slot_we = 1'b1;
        slot_wd = {item.label, (is_new ? entries_used : row_head), entries_used};
        if (!is_new && row_tail < LINK_NONE) begin
          state_next = BS_ENQ_LINK;
        end else begin
          state_next = BS_OUT;
        end
      end
      BS_ENQ_LINK: begin
        link_we    = 1'b1;
        link_wa    = row_tail[EW-1:0];
        link_wd    = entries_used - LW'(1);
        state_next = BS_OUT;
      end
      BS_DEQ_RD: begin
        state_next = BS_DEQ_WR;
      end
      BS_DEQ_WR: begin
        slot_we    = 1'b1;
        slot_wd    = {item.label, link_rd, row_tail};
        state_next = BS_OUT;
      end
      BS_LK_HEAD: begin
        state_next = BS_LK_TAIL;
      end
      BS_LK_TAIL: begin
        val_ra     = row_tail[EW-1:0];
        state_next = BS_LK_DONE;
      end
      BS_LK_DONE: begin
        state_next = BS_OUT;
      end
      BS_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = BS_IDLE;
        end
      end
      default: begin
        state_next = BS_IDLE;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= '0;
      entries_used <= '0;
    end else begin
      unique case (state)
        BS_CLEAR: begin
          idx <= idx + SW'(1);
        end
        BS_IDLE: begin
          item       <= q_item;
          idx        <= q_item.label[SW-1:0] & mask;
          step       <= '0;
          res_first  <= '0;
          res_last   <= '0;
          if (q_item.op == OP_ABSENT) begin
            res_status <= STS_ABSENT;
          end else if (q_item.op == OP_ENQ && entries_used >= LINK_NONE) begin
            res_status <= STS_EXHAUSTED;
          end else begin
            res_status <= STS_OK;
          end
        end
        BS_PROBE_CHK: begin
          row_head <= rd_head;
          row_tail <= rd_tail;
          is_new   <= (rd_key == EMPTY_KEY) || (rd_head >= LINK_NONE);
          if (rd_key == EMPTY_KEY) begin
            if (item.op != OP_ENQ) begin
              res_status <= STS_ABSENT;
            end
          end else if (rd_key == item.label) begin
            if (item.op != OP_ENQ && rd_head >= LINK_NONE) begin
              res_status <= STS_EMPTY;
            end
          end else if (step == {1'b0, mask}) begin
            res_status <= (item.op == OP_ENQ) ? STS_FULL : STS_ABSENT;
          end else begin
            // next slot is (label + step) under the mask, for any mask value
            step <= step + (SW+1)'(1);
            idx  <= (item.label[SW-1:0] + step[SW-1:0] + SW'(1)) & mask;
          end
        end
        BS_ENQ_WR: begin
          entries_used <= entries_used + LW'(1);
        end
        BS_LK_TAIL: begin
          res_first <= val_rd;
        end
        BS_LK_DONE: begin
          res_last <= (row_tail < LINK_NONE) ? val_rd : '0;
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == BS_OUT && (!out_valid || out_ready)) begin
      out_valid    <= 1'b1;
      status       <= res_status;
      first_offset <= res_first;
      last_offset  <= res_last;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
